// ===== sv/gls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gls_pkg
// Shared types, constants and helpers of the gray-level frame statistics block.
// ----------------------------------------------------------------------------
package gls_pkg;

   localparam int FmtW         = 2;
   localparam int WidthW       = 13;
   localparam int HeightW      = 13;
   localparam int StrideW      = 14;
   localparam int ByteW        = 8;
   localparam int LevelW       = 12;
   localparam int SumW         = 36;
   localparam int CountW       = 25;
   localparam int DenW         = CountW + LevelW;
   localparam int RemW         = DenW + 1;
   localparam int MeanFracBits = 16;
   localparam int MeanW        = MeanFracBits + 1;
   localparam int DivSteps     = MeanFracBits + 1;
   localparam int DivCntW      = $clog2(DivSteps);
   localparam int MaxWidth     = 4096;
   localparam int MaxHeight    = 4096;
   localparam int CsrIdxW      = 2;
   localparam int CsrDataW     = 14;

   localparam logic [FmtW-1:0] FMT_MONO8  = 2'd0;
   localparam logic [FmtW-1:0] FMT_BAYER8 = 2'd1;
   localparam logic [FmtW-1:0] FMT_MONO10 = 2'd2;
   localparam logic [FmtW-1:0] FMT_MONO12 = 2'd3;

   localparam logic [LevelW-1:0] FS_8  = 12'd255;
   localparam logic [LevelW-1:0] FS_10 = 12'd1023;
   localparam logic [LevelW-1:0] FS_12 = 12'd4095;

   localparam logic [CsrIdxW-1:0] CSR_PIXEL_FORMAT = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_FRAME_HEIGHT = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_ROW_STRIDE   = 2'd3;

   typedef struct packed {
      logic [ByteW-1:0] byte_value;
      logic             start_of_frame;
   } gls_req_type;

   typedef struct packed {
      logic              status;
      logic [LevelW-1:0] minimum_level;
      logic [LevelW-1:0] maximum_level;
      logic [LevelW-1:0] full_scale;
      logic [MeanW-1:0]  mean_q16;
      logic [CountW-1:0] pixel_total;
   } gls_rsp_type;

   typedef struct packed {
      logic take;
      logic mul;
      logic div_step;
      logic load_err;
      logic load_stats;
   } gls_cmd_type;

   typedef struct packed {
      logic bad;
      logic finish;
   } gls_stat_type;

   function automatic logic [LevelW-1:0] scale_of(input logic [FmtW-1:0] fmt);
      case (fmt)
         FMT_MONO8, FMT_BAYER8: return FS_8;
         FMT_MONO10:            return FS_10;
         FMT_MONO12:            return FS_12;
         default:               return FS_8;
      endcase
   endfunction

   function automatic logic two_bytes(input logic [FmtW-1:0] fmt);
      return (fmt == FMT_MONO10) || (fmt == FMT_MONO12);
   endfunction

endpackage
`default_nettype wire

// ===== sv/gray_level_frame_statistics.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gray_level_frame_statistics
// Min, max, count and normalized mean of one frame of raw pixel bytes.
//
//   channel  ports                               direction  transfer
//   req      req_valid/req_ready/req_data        in         one frame byte
//   rsp      rsp_valid/rsp_ready/rsp_data        out        one frame result
//   csr      csr_write_enable/index/write_data   in         register write
//
// Bytes are taken one per cycle while a frame streams in.
// After the last pixel byte the mean is computed by a count*scale multiply,
// 17 restoring divide steps and a result load; req_ready is low meanwhile.
// An invalid layout's result is presented the cycle after its frame start byte.
// req_ready also drops while a held result is not taken.
// Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module gray_level_frame_statistics
   import gls_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire gls_req_type         req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output gls_rsp_type              rsp_data,
   input  wire logic                csr_write_enable,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_write_data
);

   gls_cmd_type  cmd;
   gls_stat_type stat;

   gls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gls_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_data         (rsp_data)
   );

endmodule
`default_nettype wire

// ===== sv/gls_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gls_datapath
// Config registers, row/byte counters, min/max/sum, count multiplier,
// restoring divider for the mean and the result register.
// ----------------------------------------------------------------------------
module gls_datapath
   import gls_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_write_data,
   input  wire gls_req_type         req_data,
   input  wire gls_cmd_type         cmd,
   output gls_stat_type             stat,
   output gls_rsp_type              rsp_data
);

   logic [FmtW-1:0]    cfg_format_ff, cfg_format_in;
   logic [WidthW-1:0]  cfg_width_ff, cfg_width_in;
   logic [HeightW-1:0] cfg_height_ff, cfg_height_in;
   logic [StrideW-1:0] cfg_stride_ff, cfg_stride_in;
   logic               frame_active_ff, frame_active_in;

   logic [FmtW-1:0]    lat_format_ff, lat_format_in;
   logic [HeightW-1:0] lat_height_ff, lat_height_in;
   logic [StrideW-1:0] lat_stride_ff, lat_stride_in;
   logic [StrideW-1:0] row_bytes_ff, row_bytes_in;
   logic [LevelW-1:0]  fs_ff, fs_in;
   logic [HeightW-1:0] row_pos_ff, row_pos_in;
   logic [StrideW-1:0] byte_idx_ff, byte_idx_in;
   logic [ByteW-1:0]   held_ff, held_in;
   logic [LevelW-1:0]  min_ff, min_in;
   logic [LevelW-1:0]  max_ff, max_in;
   logic [SumW-1:0]    sum_ff, sum_in;
   logic [CountW-1:0]  cnt_ff, cnt_in;
   logic [DenW-1:0]    den_ff, den_in;
   logic [RemW-1:0]    rem_ff, rem_in;
   logic [MeanW-1:0]   quo_ff, quo_in;
   gls_rsp_type        rsp_ff, rsp_in;

   logic                      sof;
   logic [FmtW-1:0]           fmt_w;
   logic                      two_w;
   logic [LevelW-1:0]         fs_w;
   logic [StrideW-1:0]        cfg_row_bytes;
   logic [StrideW-1:0]        row_bytes_w;
   logic [StrideW-1:0]        stride_w;
   logic [HeightW-1:0]        height_w;
   logic [StrideW-1:0]        byte_idx_w;
   logic [HeightW-1:0]        row_w;
   logic [ByteW-1:0]          held_w;
   logic [LevelW-1:0]         min_w;
   logic [LevelW-1:0]         max_w;
   logic [SumW-1:0]           sum_w;
   logic                      bad;
   logic                      active_w;
   logic                      in_pixels;
   logic                      have_pix;
   logic [2*ByteW-1:0]        pix16;
   logic [LevelW-1:0]         v;
   logic                      last_byte;
   logic                      last_row;
   logic [StrideW:0]          idx_next;
   logic [WidthW+HeightW-1:0] area;
   logic [DenW-1:0]           den_prod;
   logic                      ge;
   logic [RemW-1:0]           diff;
   logic [RemW-1:0]           r_next;

   always_comb begin
      cfg_format_in = cfg_format_ff;
      cfg_width_in  = cfg_width_ff;
      cfg_height_in = cfg_height_ff;
      cfg_stride_in = cfg_stride_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PIXEL_FORMAT: cfg_format_in = csr_write_data[FmtW-1:0];
            CSR_FRAME_WIDTH:  cfg_width_in  = csr_write_data[WidthW-1:0];
            CSR_FRAME_HEIGHT: cfg_height_in = csr_write_data[HeightW-1:0];
            CSR_ROW_STRIDE:   cfg_stride_in = csr_write_data[StrideW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      sof           = cmd.take && req_data.start_of_frame;
      fmt_w         = sof ? cfg_format_ff : lat_format_ff;
      two_w         = two_bytes(fmt_w);
      fs_w          = scale_of(fmt_w);
      cfg_row_bytes = two_bytes(cfg_format_ff) ? {cfg_width_ff, 1'b0} : {1'b0, cfg_width_ff};
      row_bytes_w   = sof ? cfg_row_bytes : row_bytes_ff;
      stride_w      = sof ? cfg_stride_ff : lat_stride_ff;
      height_w      = sof ? cfg_height_ff : lat_height_ff;
      byte_idx_w    = sof ? '0 : byte_idx_ff;
      row_w         = sof ? '0 : row_pos_ff;
      held_w        = sof ? '0 : held_ff;
      min_w         = sof ? fs_w : min_ff;
      max_w         = sof ? '0 : max_ff;
      sum_w         = sof ? '0 : sum_ff;

      bad = sof && ((cfg_width_ff == '0) || (cfg_height_ff == '0) ||
                    (cfg_width_ff > WidthW'(MaxWidth)) ||
                    (cfg_height_ff > HeightW'(MaxHeight)) ||
                    (cfg_stride_ff < cfg_row_bytes));
      active_w = sof ? !bad : frame_active_ff;

      in_pixels = byte_idx_w < row_bytes_w;
      have_pix  = in_pixels && (!two_w || byte_idx_w[0]);
      pix16     = {req_data.byte_value, held_w};
      v         = two_w ? (pix16[LevelW-1:0] & fs_w)
                        : {{(LevelW-ByteW){1'b0}}, req_data.byte_value};
      last_byte = byte_idx_w == (row_bytes_w - 1'b1);
      last_row  = ({1'b0, row_w} + 1'b1) >= {1'b0, height_w};
      idx_next  = {1'b0, byte_idx_w} + 1'b1;

      stat.bad    = bad;
      stat.finish = cmd.take && active_w && in_pixels && last_byte && last_row;

      frame_active_in = cmd.take ? (active_w && !stat.finish) : frame_active_ff;

      lat_format_in = lat_format_ff;
      lat_height_in = lat_height_ff;
      lat_stride_in = lat_stride_ff;
      row_bytes_in  = row_bytes_ff;
      fs_in         = fs_ff;
      cnt_in        = cnt_ff;
      area          = cfg_width_ff * cfg_height_ff;
      if (sof) begin
         lat_format_in = cfg_format_ff;
         lat_height_in = cfg_height_ff;
         lat_stride_in = cfg_stride_ff;
         row_bytes_in  = cfg_row_bytes;
         fs_in         = fs_w;
         cnt_in        = area[CountW-1:0];
      end

      row_pos_in  = row_pos_ff;
      byte_idx_in = byte_idx_ff;
      held_in     = held_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      sum_in      = sum_ff;
      if (cmd.take && active_w) begin
         held_in = held_w;
         min_in  = min_w;
         max_in  = max_w;
         sum_in  = sum_w;
         if (in_pixels && two_w && !byte_idx_w[0]) begin
            held_in = req_data.byte_value;
         end
         if (have_pix) begin
            if (v < min_w) begin
               min_in = v;
            end
            if (v > max_w) begin
               max_in = v;
            end
            sum_in = sum_w + {{(SumW-LevelW){1'b0}}, v};
         end
         if (idx_next >= {1'b0, stride_w}) begin
            byte_idx_in = '0;
            row_pos_in  = row_w + 1'b1;
         end else begin
            byte_idx_in = idx_next[StrideW-1:0];
            row_pos_in  = row_w;
         end
      end

      den_prod = cnt_ff * fs_ff;
      ge       = rem_ff >= {1'b0, den_ff};
      diff     = rem_ff - {1'b0, den_ff};
      r_next   = ge ? diff : rem_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (cmd.mul) begin
         den_in = den_prod;
         rem_in = {{(RemW-SumW){1'b0}}, sum_ff};
         quo_in = '0;
      end else if (cmd.div_step) begin
         rem_in = {r_next[RemW-2:0], 1'b0};
         quo_in = {quo_ff[MeanW-2:0], ge};
      end

      rsp_in = rsp_ff;
      if (cmd.load_err) begin
         rsp_in        = '0;
         rsp_in.status = 1'b1;
      end else if (cmd.load_stats) begin
         rsp_in.status        = 1'b0;
         rsp_in.minimum_level = min_ff;
         rsp_in.maximum_level = max_ff;
         rsp_in.full_scale    = fs_ff;
         rsp_in.mean_q16      = quo_ff;
         rsp_in.pixel_total   = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_format_ff   <= '0;
         cfg_width_ff    <= '0;
         cfg_height_ff   <= '0;
         cfg_stride_ff   <= '0;
         frame_active_ff <= 1'b0;
      end else begin
         cfg_format_ff   <= cfg_format_in;
         cfg_width_ff    <= cfg_width_in;
         cfg_height_ff   <= cfg_height_in;
         cfg_stride_ff   <= cfg_stride_in;
         frame_active_ff <= frame_active_in;
      end
   end

   always_ff @(posedge clock) begin
      lat_format_ff <= lat_format_in;
      lat_height_ff <= lat_height_in;
      lat_stride_ff <= lat_stride_in;
      row_bytes_ff  <= row_bytes_in;
      fs_ff         <= fs_in;
      row_pos_ff    <= row_pos_in;
      byte_idx_ff   <= byte_idx_in;
      held_ff       <= held_in;
      min_ff        <= min_in;
      max_ff        <= max_in;
      sum_ff        <= sum_in;
      cnt_ff        <= cnt_in;
      den_ff        <= den_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   a_layout_fits: assert property (@(posedge clock) disable iff (reset)
      frame_active_ff |-> (row_bytes_ff != '0) && (row_bytes_ff <= lat_stride_ff))
      else $error("active frame with row wider than stride");

   a_idx_in_stride: assert property (@(posedge clock) disable iff (reset)
      frame_active_ff |-> byte_idx_ff < lat_stride_ff)
      else $error("byte index beyond stride");

   a_mean_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load_stats |-> quo_ff <= MeanW'(1 << MeanFracBits))
      else $error("mean above full scale");

endmodule
`default_nettype wire

// ===== sv/gls_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gls_ctrl
// Sequencer: byte streaming, end-of-frame multiply and divide, result valid.
// ----------------------------------------------------------------------------
module gls_ctrl
   import gls_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire gls_stat_type stat,
   output gls_cmd_type       cmd
);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_MUL,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type          state_ff;
   logic [DivCntW-1:0] step_ff;
   logic               rsp_valid_ff;

   always_comb begin
      req_ready      = (state_ff == ST_RUN) && (!rsp_valid_ff || rsp_ready);
      cmd.take       = req_valid && req_ready;
      cmd.mul        = state_ff == ST_MUL;
      cmd.div_step   = state_ff == ST_DIV;
      cmd.load_err   = cmd.take && stat.bad;
      cmd.load_stats = state_ff == ST_FINISH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_err || cmd.load_stats) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_RUN: begin
               if (cmd.take && stat.finish) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               step_ff  <= DivCntW'(DivSteps - 1);
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (step_ff == '0) begin
                  state_ff <= ST_FINISH;
               end else begin
                  step_ff <= step_ff - 1'b1;
               end
            end
            ST_FINISH: begin
               state_ff <= ST_RUN;
            end
            default: begin
               state_ff <= ST_RUN;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_finish_starts_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.take && stat.finish |=> state_ff == ST_MUL)
      else $error("frame end did not start the mean computation");

   a_bad_finish_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> !(stat.bad && stat.finish))
      else $error("error and frame end in one transfer");

   a_finish_sets_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |=> rsp_valid_ff)
      else $error("statistics result not presented");

endmodule
`default_nettype wire

// ===== tb/sv/gls_stats_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gls_stats_checker
// Watches the byte, result and register ports of the frame statistics block.
// Keeps its own model of the frame walk, queues the result an accepted byte
// should produce, if any, and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module gls_stats_checker
   import gls_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  gls_req_type         req_data,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  gls_rsp_type         rsp_data,
   input  logic                csr_write_enable,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_write_data,
   output int                  mismatches,
   output int                  awaited,
   output int                  stats_seen,
   output int                  errors_seen
);

   logic [FmtW-1:0]    reg_format;
   logic [WidthW-1:0]  reg_width;
   logic [HeightW-1:0] reg_height;
   logic [StrideW-1:0] reg_stride;

   logic [FmtW-1:0]    frame_format;
   logic [WidthW-1:0]  frame_w;
   logic [HeightW-1:0] frame_h;
   logic [StrideW-1:0] frame_stride;
   int unsigned        frame_bpp;

   logic [HeightW-1:0] row_index;
   int unsigned        column_byte;
   logic [ByteW-1:0]   low_half;
   logic [LevelW-1:0]  level_min;
   logic [LevelW-1:0]  level_max;
   logic [SumW-1:0]    level_sum;
   bit                 in_frame;

   gls_rsp_type        frame_results_due[$];

   function automatic logic [LevelW-1:0] level_span(input logic [FmtW-1:0] fmt);
      case (fmt)
         FMT_MONO10: return FS_10;
         FMT_MONO12: return FS_12;
         default:    return FS_8;
      endcase
   endfunction

   task automatic flag_mismatch(input string what);
      $display("[%0t] gls check: %s", $time, what);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input longint unsigned got,
                                input longint unsigned want);
      if (got != want) begin
         flag_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   // One frame byte through the model; emitted is set when it closes a frame
   // or is refused at frame start.
   task automatic walk_byte(input gls_req_type item, output bit emitted,
                            output gls_rsp_type stats);
      int unsigned       row_bytes;
      logic [LevelW-1:0] level;
      bit                have_level;
      bit                last_byte;
      longint unsigned   span_den;
      longint unsigned   scaled;
      emitted    = 1'b0;
      stats      = '0;
      level      = '0;
      have_level = 1'b0;
      last_byte  = 1'b0;
      if (item.start_of_frame) begin
         frame_format = reg_format;
         frame_w      = reg_width;
         frame_h      = reg_height;
         frame_stride = reg_stride;
         frame_bpp    = (frame_format == FMT_MONO10 || frame_format == FMT_MONO12) ? 2 : 1;
         row_index    = '0;
         column_byte  = 0;
         low_half     = '0;
         level_min    = level_span(frame_format);
         level_max    = '0;
         level_sum    = '0;
         if (frame_w == 0 || frame_h == 0 || frame_w > MaxWidth || frame_h > MaxHeight ||
             frame_stride < frame_w * frame_bpp) begin
            in_frame     = 1'b0;
            stats.status = 1'b1;
            emitted      = 1'b1;
            return;
         end
         in_frame = 1'b1;
      end
      if (!in_frame) return;

      row_bytes = frame_w * frame_bpp;
      if (column_byte < row_bytes) begin
         if (frame_bpp == 1) begin
            level      = LevelW'(item.byte_value);
            have_level = 1'b1;
         end else if (column_byte[0] == 1'b0) begin
            low_half = item.byte_value;
         end else begin
            level      = LevelW'({item.byte_value, low_half}) & level_span(frame_format);
            have_level = 1'b1;
         end
         if (have_level) begin
            if (level < level_min) level_min = level;
            if (level > level_max) level_max = level;
            level_sum = level_sum + level;
         end
         last_byte = (column_byte == row_bytes - 1) && (row_index + 1 >= frame_h);
      end

      if (column_byte + 1 >= frame_stride) begin
         column_byte = 0;
         row_index   = row_index + 1'b1;
      end else begin
         column_byte++;
      end

      if (last_byte) begin
         in_frame           = 1'b0;
         stats.minimum_level = level_min;
         stats.maximum_level = level_max;
         stats.full_scale    = level_span(frame_format);
         stats.pixel_total   = CountW'(frame_w) * CountW'(frame_h);
         span_den = 64'(frame_w) * 64'(frame_h) * 64'(stats.full_scale);
         scaled   = (64'(level_sum) << MeanFracBits) / span_den;
         stats.mean_q16 = scaled[MeanW-1:0];
         emitted = 1'b1;
      end
   endtask

   always @(posedge clock) begin : watch
      bit          emitted;
      gls_rsp_type stats;
      gls_rsp_type oldest;
      if (reset) begin
         reg_format   = FMT_MONO8;
         reg_width    = '0;
         reg_height   = '0;
         reg_stride   = '0;
         frame_format = FMT_MONO8;
         frame_w      = '0;
         frame_h      = '0;
         frame_stride = '0;
         frame_bpp    = 1;
         row_index    = '0;
         column_byte  = 0;
         low_half     = '0;
         level_min    = FS_12;
         level_max    = '0;
         level_sum    = '0;
         in_frame     = 1'b0;
         frame_results_due.delete();
         mismatches  = 0;
         stats_seen  = 0;
         errors_seen = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PIXEL_FORMAT: reg_format = csr_write_data[FmtW-1:0];
               CSR_FRAME_WIDTH:  reg_width  = csr_write_data[WidthW-1:0];
               CSR_FRAME_HEIGHT: reg_height = csr_write_data[HeightW-1:0];
               CSR_ROW_STRIDE:   reg_stride = csr_write_data[StrideW-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            walk_byte(req_data, emitted, stats);
            if (emitted) frame_results_due = {frame_results_due, stats};
         end
         if (rsp_valid && rsp_ready) begin
            if (frame_results_due.size() == 0) begin
               flag_mismatch("result transfer with no frame result due");
            end else begin
               oldest = frame_results_due.pop_front();
               compare_field("status", rsp_data.status, oldest.status);
               compare_field("minimum_level", rsp_data.minimum_level, oldest.minimum_level);
               compare_field("maximum_level", rsp_data.maximum_level, oldest.maximum_level);
               compare_field("full_scale", rsp_data.full_scale, oldest.full_scale);
               compare_field("mean_q16", rsp_data.mean_q16, oldest.mean_q16);
               compare_field("pixel_total", rsp_data.pixel_total, oldest.pixel_total);
               if (oldest.status) errors_seen++;
               else stats_seen++;
            end
         end
      end
      awaited = frame_results_due.size();
   end

endmodule

// ===== tb/sv/gray_level_frame_statistics_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gray_level_frame_statistics_test
// Streams frames of raw bytes through the statistics block under all pixel
// formats and many layouts: refused layouts, padded rows, restarts, stray bytes and
// the largest sizes. A checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module gray_level_frame_statistics_test;
   import gls_pkg::*;

   localparam int RandomBytes  = 1750;
   localparam int SettleCycles = 24;
   localparam int TailCycles   = 40;
   localparam int HoldCycles   = 400;
   localparam int StallLimit   = 2000;
   localparam int IdlePercent  = 9;

   typedef enum int {
      CONTENT_RANDOM,
      CONTENT_ZERO,
      CONTENT_FULL,
      CONTENT_EDGES
   } content_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   gls_req_type        req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   gls_rsp_type        rsp_data;
   logic               csr_write_enable;
   logic [CsrIdxW-1:0] csr_index;
   logic [CsrDataW-1:0] csr_write_data;

   int mismatches;
   int awaited;
   int stats_seen;
   int errors_seen;

   int              bytes_sent;
   int              layouts_set;
   int              restarts;
   bit              steady;
   logic [FmtW-1:0] cur_format;
   int              cur_width;
   int              cur_height;
   int              cur_stride;

   gray_level_frame_statistics dut (.*);

   gls_stats_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < StallLimit) begin
         @(posedge clock);
         if (reset || csr_write_enable || (req_valid && req_ready) ||
             (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("gray_level_frame_statistics: mismatch");
      $finish;
   end

   // result side: random stalls, plus one long hold while bytes are still offered
   initial begin : receiver
      int hold_left;
      bit held;
      hold_left = 0;
      held      = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && rsp_valid && req_valid && stats_seen >= 12) begin
            held      = 1'b1;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= IdlePercent);
         end
      end
   end

   task automatic push_byte(input logic [ByteW-1:0] value, input bit sof);
      while (!steady && $urandom_range(99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid                <= 1'b1;
      req_data.byte_value     <= value;
      req_data.start_of_frame <= sof;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic wait_drained(input int extra);
      req_valid <= 1'b0;
      while (awaited != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic program_layout(input logic [FmtW-1:0] fmt, input int w, input int h,
                                 input int stride);
      wait_drained(SettleCycles);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_PIXEL_FORMAT;
      csr_write_data   <= CsrDataW'(fmt);
      @(negedge clock);
      csr_index        <= CSR_FRAME_WIDTH;
      csr_write_data   <= CsrDataW'(w);
      @(negedge clock);
      csr_index        <= CSR_FRAME_HEIGHT;
      csr_write_data   <= CsrDataW'(h);
      @(negedge clock);
      csr_index        <= CSR_ROW_STRIDE;
      csr_write_data   <= CsrDataW'(stride);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cur_format = fmt;
      cur_width  = w;
      cur_height = h;
      cur_stride = stride;
      layouts_set++;
   endtask

   // bytes of a whole frame under the current layout, 0 when it is refused
   function automatic int frame_bytes();
      int bpp;
      bpp = (cur_format == FMT_MONO10 || cur_format == FMT_MONO12) ? 2 : 1;
      if (cur_width == 0 || cur_height == 0 || cur_width > MaxWidth ||
          cur_height > MaxHeight || cur_stride < cur_width * bpp) return 0;
      return cur_stride * (cur_height - 1) + cur_width * bpp;
   endfunction

   function automatic logic [ByteW-1:0] byte_for(input content_type flavor);
      case (flavor)
         CONTENT_ZERO:  return 8'h00;
         CONTENT_FULL:  return 8'hFF;
         CONTENT_EDGES: return $urandom_range(1) ? 8'hFF : 8'h00;
         default:       return ByteW'($urandom_range(255));
      endcase
   endfunction

   // count bytes starting with a frame start, then tail bytes outside a frame
   task automatic send_frame(input int count, input content_type flavor, input int tail);
      for (int i = 0; i < count; i++) push_byte(byte_for(flavor), i == 0);
      for (int i = 0; i < tail; i++) push_byte(ByteW'($urandom_range(255)), 1'b0);
   endtask

   initial begin : stimulus
      int              random_bytes;
      int              full;
      int              frames;
      int              cut;
      int              tail;
      int              w;
      int              h;
      int              bpp;
      int              stride;
      logic [FmtW-1:0] fmt;
      content_type     flavor;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_PIXEL_FORMAT;
      csr_write_data   = '0;
      bytes_sent       = 0;
      layouts_set      = 0;
      restarts         = 0;
      steady           = 1'b0;
      cur_format       = FMT_MONO8;
      cur_width        = 0;
      cur_height       = 0;
      cur_stride       = 0;
      random_bytes     = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // stray byte with no frame, then a frame start under the reset layout
      push_byte(8'hA5, 1'b0);
      send_frame(1, CONTENT_RANDOM, 1);

      program_layout(FMT_MONO8, 3, 2, 5);
      send_frame(frame_bytes(), CONTENT_EDGES, 2);
      program_layout(FMT_BAYER8, 2, 1, 2);
      send_frame(frame_bytes(), CONTENT_FULL, 0);
      send_frame(frame_bytes(), CONTENT_ZERO, 0);
      program_layout(FMT_MONO10, 2, 2, 6);
      send_frame(3, CONTENT_RANDOM, 0);
      restarts++;
      send_frame(frame_bytes(), CONTENT_FULL, 0);
      program_layout(FMT_MONO12, 1, 1, 2);
      send_frame(frame_bytes(), CONTENT_FULL, 1);
      send_frame(frame_bytes(), CONTENT_RANDOM, 0);

      // refused layouts
      program_layout(FMT_MONO8, 0, 1, 1);
      send_frame(1, CONTENT_RANDOM, 0);
      program_layout(FMT_MONO8, 5, 0, 5);
      send_frame(2, CONTENT_RANDOM, 0);
      program_layout(FMT_MONO12, 3, 1, 5);
      send_frame(2, CONTENT_RANDOM, 0);
      program_layout(FMT_BAYER8, MaxWidth + 1, 1, 16383);
      send_frame(1, CONTENT_RANDOM, 0);
      program_layout(FMT_MONO10, 1, MaxHeight + 1, 2);
      send_frame(1, CONTENT_RANDOM, 0);
      program_layout(FMT_MONO8, 8191, 8191, 16383);
      send_frame(1, CONTENT_RANDOM, 0);
      program_layout(FMT_MONO8, 1, 1, 0);
      send_frame(1, CONTENT_RANDOM, 0);

      // largest accepted width and height: the frame opens, no result, and
      // the next frame start drops it
      program_layout(FMT_MONO8, MaxWidth, 1, 16383);
      send_frame(8, CONTENT_RANDOM, 0);
      restarts++;
      program_layout(FMT_BAYER8, 1, MaxHeight, 1);
      send_frame(8, CONTENT_RANDOM, 0);
      restarts++;

      while (random_bytes < RandomBytes) begin
         fmt = FmtW'($urandom_range(3));
         bpp = (fmt == FMT_MONO10 || fmt == FMT_MONO12) ? 2 : 1;
         if ($urandom_range(19) == 0) begin
            w = $urandom_range(7, 40);
            h = $urandom_range(5, 12);
         end else begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 4);
         end
         stride = w * bpp + (($urandom_range(2) == 0) ? 0 : $urandom_range(1, 3));
         if ($urandom_range(99) < 15) begin
            case ($urandom_range(4))
               0: w = 0;
               1: h = 0;
               2: w = $urandom_range(MaxWidth + 1, 8191);
               3: h = $urandom_range(MaxHeight + 1, 8191);
               default: stride = $urandom_range(0, w * bpp - 1);
            endcase
         end
         program_layout(fmt, w, h, stride);
         full   = frame_bytes();
         frames = $urandom_range(1, 4);
         for (int f = 0; f < frames; f++) begin
            case ($urandom_range(9))
               0:       flavor = CONTENT_ZERO;
               1:       flavor = CONTENT_FULL;
               2:       flavor = CONTENT_EDGES;
               default: flavor = CONTENT_RANDOM;
            endcase
            tail = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
            if (full == 0) begin
               send_frame(1, flavor, tail);
               random_bytes += 1;
            end else if (f < frames - 1 && full > 1 && $urandom_range(99) < 10) begin
               // cut short; the next frame start drops it
               cut = $urandom_range(1, full - 1);
               send_frame(cut, flavor, 0);
               restarts++;
               random_bytes += cut;
            end else begin
               send_frame(full, flavor, tail);
               random_bytes += full;
            end
            steady = (random_bytes >= 500 && random_bytes < 900);
         end
      end

      steady = 1'b0;
      wait_drained(TailCycles);
      $display("covered %0d bytes over %0d layouts in all four pixel formats",
               bytes_sent, layouts_set);
      $display("%0d frames with statistics, %0d refused layouts, %0d frames cut short",
               stats_seen, errors_seen, restarts);
      if (mismatches == 0 && awaited == 0) begin
         $display("gray_level_frame_statistics: match");
      end else begin
         $display("gray_level_frame_statistics: mismatch");
      end
      $finish;
   end

endmodule
